/* design/mis_pkg.sv */
// Package with shared constants and types for the merge insertion sorter.
`default_nettype none
package mis_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned ValW = 31;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW = AddrW + 1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFew = 2'd1;
  localparam logic [1:0] StOvf = 2'd2;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RDA  = 6'b000010,
    S_CMP  = 6'b000100,
    S_WRB  = 6'b001000,
    S_OUTR = 6'b010000,
    S_OUTW = 6'b100000
  } state_e;

  // Memory port request.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ValW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

/* design/merge_insertion_sorter.sv */
// Top level of the merge insertion sorter.
// Values load one word per cycle, while s_axis_tready is high, into a
// 64-entry store. A word with tlast starts an in-place insertion sort: each
// stored entry is taken as key and shifted down past larger predecessors.
// While shifting, the single memory port does one read-compare-write per
// cycle, and each key is also fetched and placed. The sorted run is then
// read out word by word while the receiver is ready, last word with tlast.
// Input is held off while sorting or emitting.
`default_nettype none
module merge_insertion_sorter
  import mis_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [30:0] value
  input  wire logic        s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [30:0] sorted_value
  output logic             m_axis_tlast,   // final_flag
  output logic [1:0]       m_axis_tuser    // status
);
  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;
  logic [CntW-1:0] i_q, i_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [ValW-1:0] key_q, key_d;
  logic [1:0] st_q, st_d;
  logic ov_q, ov_d;
  logic [ValW-1:0] ovv_q, ovv_d;
  logic ol_q, ol_d;
  logic [ValW-1:0] rdata;
  mem_req_t req;
  logic acc_in, out_free;

  mis_ram u_ram (.clk_i, .req_i(req), .rdata_o(rdata));

  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_LOAD) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {1'b0, ovv_q};
  assign m_axis_tlast = ol_q;
  assign m_axis_tuser = st_q;

  // Sequencer: load, sort by insertion, emit.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ovf_d = ovf_q; i_d = i_q; j_d = j_q;
    key_d = key_q; st_d = st_q; ov_d = ov_q; ovv_d = ovv_q; ol_d = ol_q;
    req = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        req.raddr = '0;
        if (acc_in) begin
          if (cnt_q < CntW'(Capacity)) begin
            req.we = 1'b1; req.waddr = cnt_q[AddrW-1:0];
            req.wdata = s_axis_tdata[ValW-1:0];
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            st_d = (ovf_q || cnt_q >= CntW'(Capacity)) ? StOvf : StOk;
            if (cnt_q == '0) begin
              // Single value: emit straight from the input word.
              ov_d = 1'b1; ovv_d = s_axis_tdata[ValW-1:0]; ol_d = 1'b1; st_d = StFew;
              cnt_d = '0; ovf_d = 1'b0;
            end else begin
              i_d = CntW'(1);
              req.raddr = '0;
              state_d = S_RDA;
              // key for i=1 is read back from the store in S_RDA
            end
          end
        end
      end
      S_RDA: begin
        // Read key at i; j = i; once i reaches the count, start output.
        if (i_q >= cnt_q) begin
          i_d = '0; state_d = S_OUTR;
        end else begin
          req.raddr = i_q[AddrW-1:0];
          j_d = i_q[AddrW-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // Key arrives this cycle when j == i; at j == 0 write the key back, else issue read of j-1.
        if (j_q == i_q[AddrW-1:0]) key_d = rdata;
        if (j_q == '0) begin
          req.we = 1'b1; req.waddr = j_q;
          req.wdata = (j_q == i_q[AddrW-1:0]) ? rdata : key_q;
          i_d = i_q + 1'b1; state_d = S_RDA;
        end else begin
          req.raddr = j_q - 1'b1;
          state_d = S_WRB;
        end
      end
      S_WRB: begin
        // Compare predecessor with key; shift or place.
        req.we = 1'b1; req.waddr = j_q;
        if (rdata > key_q) begin
          req.wdata = rdata;
          j_d = j_q - 1'b1;
          if (j_q == AddrW'(1)) begin
            req.waddr = j_q;
            state_d = S_CMP;
          end else begin
            req.raddr = j_q - AddrW'(2);
            state_d = S_WRB;
          end
        end else begin
          req.wdata = key_q;
          i_d = i_q + 1'b1; state_d = S_RDA;
        end
      end
      S_OUTR: begin
        req.raddr = i_q[AddrW-1:0];
        if (out_free || !ov_d) state_d = S_OUTW;
      end
      S_OUTW: begin
        if (!ov_d) begin
          ov_d = 1'b1; ovv_d = rdata;
          ol_d = (i_q + 1'b1 == cnt_q);
          if (cnt_q == CntW'(1)) st_d = StFew;
          if (i_q + 1'b1 == cnt_q) begin
            cnt_d = '0; ovf_d = 1'b0; state_d = S_LOAD;
          end else begin
            i_d = i_q + 1'b1; state_d = S_OUTR;
          end
        end else begin
          req.raddr = i_q[AddrW-1:0];
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; cnt_q <= '0; ovf_q <= 1'b0; i_q <= '0; j_q <= '0;
      ov_q <= 1'b0; st_q <= StOk; ol_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; i_q <= i_d; j_q <= j_d;
      ov_q <= ov_d; st_q <= st_d; ol_q <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; ovv_q <= ovv_d;
  end
endmodule
`default_nettype wire

/* design/mis_ram.sv */
// Single-port-write, single-read value store with registered read data.
`default_nettype none
module mis_ram
  import mis_pkg::*;
(
  input  wire logic            clk_i,
  input  wire mem_req_t        req_i,
  output logic [ValW-1:0]      rdata_o
);
  logic [ValW-1:0] mem_q [Capacity];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule
`default_nettype wire

/* sim/tb_merge_insertion_sorter.sv */
// Self-checking testbench for the merge insertion sorter stream block.
`default_nettype none
module tb_merge_insertion_sorter
  import mis_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            fin;
    logic [1:0]      status;
  } sorted_word_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
    logic            has_exp;
    logic [ValW-1:0] exp_value;
    logic [1:0]      exp_status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [1:0] m_axis_tuser;

  merge_insertion_sorter dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: the values loaded so far and whether one was dropped.
  logic [ValW-1:0] loaded_q[$];
  logic dropped_seen;
  sorted_word_t sorted_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  // Receiver idling: cycles still to wait and whether a new wait is due.
  int rx_wait = 0;
  bit rx_took = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Store one value and, on the last one, queue the sorted run.
  task automatic predict_word(input logic [ValW-1:0] v, input logic last);
    logic [ValW-1:0] run[$];
    logic [1:0] st;
    sorted_word_t w;
    if (loaded_q.size() < Capacity) loaded_q = {loaded_q, v};
    else dropped_seen = 1'b1;
    if (last) begin
      run = loaded_q;
      run.sort();
      if (run.size() < 2) begin
        w = '{run[0], 1'b1, StFew};
        sorted_q = {sorted_q, w};
      end else begin
        st = dropped_seen ? StOvf : StOk;
        foreach (run[k]) begin
          w = '{run[k], k == run.size() - 1, st};
          sorted_q = {sorted_q, w};
        end
      end
      loaded_q.delete();
      dropped_seen = 1'b0;
    end
  endtask

  // Send one word, honoring a random gap before it; called at a falling edge.
  task automatic send_word(input logic [ValW-1:0] v, input logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, v};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(v, last);
    @(negedge clk_i);
  endtask

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return ValW'($urandom_range(0, 15));
      1: return {ValW{1'b1}} - ValW'($urandom_range(0, 3));
      default: return ValW'($urandom());
    endcase
  endfunction

  // Receiver: hold tready low for a random wait, drawn anew after each taken word.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_took) begin
        rx_wait = $urandom_range(0, 4);
        rx_took = 1'b0;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each taken word against the oldest expectation.
  always @(posedge clk_i) begin
    sorted_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_took = 1'b1;
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = sorted_q.pop_front();
        if (m_axis_tdata[ValW-1:0] !== want.value)
          report_mismatch($sformatf("value %h, want %h", m_axis_tdata[ValW-1:0], want.value));
        if (m_axis_tlast !== want.fin)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.fin));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
      end
    end
  end

  // Directed rows: single values and extremes; expected value typed where obvious.
  stim_row_t directed[] = '{
    '{31'h7fffffff, 1'b1, 1'b1, 31'h7fffffff, StFew},
    '{31'h0, 1'b1, 1'b1, 31'h0, StFew},
    '{31'h7fffffff, 1'b0, 1'b0, '0, StOk},
    '{31'h0, 1'b0, 1'b0, '0, StOk},
    '{31'h55555555, 1'b0, 1'b0, '0, StOk},
    '{31'h2aaaaaaa, 1'b0, 1'b0, '0, StOk},
    '{31'h0, 1'b0, 1'b0, '0, StOk},
    '{31'h7fffffff, 1'b1, 1'b0, '0, StOk},
    '{31'h5, 1'b0, 1'b0, '0, StOk},
    '{31'h5, 1'b1, 1'b0, '0, StOk}
  };

  initial begin
    int sets;
    int n;
    dropped_seen = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) begin
      send_word(directed[i].value, directed[i].last);
      if (directed[i].has_exp) begin
        if (sorted_q.size() == 0 || sorted_q[$].value !== directed[i].exp_value ||
            sorted_q[$].status !== directed[i].exp_status)
          report_mismatch("directed row prediction disagrees");
      end
    end
    // Overflow: a full store plus two dropped words, the last one dropped too.
    for (int i = 0; i < Capacity + 2; i++) send_word(rand_value(), i == Capacity + 1);
    // Random sets, mostly small, a few near or past capacity.
    sets = 0;
    n = directed.size() + Capacity + 2;
    while (n < 410) begin
      int len;
      case ($urandom_range(0, 9))
        0: len = $urandom_range(Capacity - 1, Capacity + 3);
        1: len = 1;
        default: len = $urandom_range(2, 12);
      endcase
      for (int i = 0; i < len; i++) send_word(rand_value(), i == len - 1);
      n += len;
      sets++;
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("merge_insertion_sorter: match");
    end else begin
      $display("merge_insertion_sorter: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("merge_insertion_sorter: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
design/mis_pkg.sv
design/mis_ram.sv
design/merge_insertion_sorter.sv
sim/tb_merge_insertion_sorter.sv
